// ----- design/zsmm_pkg.sv -----
// ----------------------------------------------------------------------------
// zsmm_pkg
// Shared constants, types and arithmetic helpers for the zero-skip Q16.16
// matrix multiply block.
// ----------------------------------------------------------------------------
package zsmm_pkg;

   localparam int MAX_DIM     = 16;
   localparam int DIM_CAP     = (MAX_DIM < 16) ? MAX_DIM : 16;
   localparam int IDX_W       = $clog2(DIM_CAP);
   localparam int CNT_W       = $clog2(DIM_CAP + 1);
   localparam int CFG_W       = 5;
   localparam int DATA_W      = 32;
   localparam int PADDR_W     = 4;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int RESET_DIM   = 16;

   localparam logic [1:0] ACT_LOAD_A  = 2'd0;
   localparam logic [1:0] ACT_LOAD_B  = 2'd1;
   localparam logic [1:0] ACT_COMPUTE = 2'd2;

   localparam logic [1:0] REG_A_ROWS = 2'd0;
   localparam logic [1:0] REG_INNER  = 2'd1;
   localparam logic [1:0] REG_B_COLS = 2'd2;

   typedef enum logic [1:0] {
      OP_LOAD_A,
      OP_LOAD_B,
      OP_COMPUTE
   } op_type;

   typedef struct packed {
      logic [CNT_W-1:0] rows;
      logic [CNT_W-1:0] inner;
      logic [CNT_W-1:0] cols;
   } dims_type;

   typedef struct packed {
      op_type             op;
      logic [IDX_W-1:0]   row;
      logic [IDX_W-1:0]   col;
      logic signed [31:0] value;
   } job_type;

   function automatic logic [CNT_W-1:0] eff_dim(input logic [CFG_W-1:0] r);
      logic [CNT_W-1:0] d;
      if (r == '0) begin
         d = CNT_W'(1);
      end else if (int'(r) > DIM_CAP) begin
         d = CNT_W'(DIM_CAP);
      end else begin
         d = CNT_W'(r);
      end
      return d;
   endfunction

   // saturate a 49-bit signed value to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
      logic signed [31:0] s;
      if ((&v[48:31]) || !(|v[48:31])) begin
         s = v[31:0];
      end else if (v[48]) begin
         s = 32'sh8000_0000;
      end else begin
         s = 32'sh7FFF_FFFF;
      end
      return s;
   endfunction

endpackage

// ----- design/zsmm_csr.sv -----
// ----------------------------------------------------------------------------
// zsmm_csr
// Dimension registers behind the APB-style port, with readback and the
// clamped sizes used by the datapath.
// ----------------------------------------------------------------------------
module zsmm_csr
   import zsmm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [PADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0]  csr_pwdata,
   output logic [DATA_W-1:0]  csr_prdata,
   output logic               csr_pready,
   output dims_type           dims
);

   logic [CFG_W-1:0] a_rows_ff;
   logic [CFG_W-1:0] inner_ff;
   logic [CFG_W-1:0] b_cols_ff;
   logic             wr_en;
   logic [1:0]       reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         a_rows_ff <= CFG_W'(RESET_DIM);
         inner_ff  <= CFG_W'(RESET_DIM);
         b_cols_ff <= CFG_W'(RESET_DIM);
      end else if (wr_en) begin
         unique case (reg_sel)
            REG_A_ROWS: a_rows_ff <= csr_pwdata[CFG_W-1:0];
            REG_INNER:  inner_ff  <= csr_pwdata[CFG_W-1:0];
            REG_B_COLS: b_cols_ff <= csr_pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_A_ROWS: csr_prdata = DATA_W'(a_rows_ff);
         REG_INNER:  csr_prdata = DATA_W'(inner_ff);
         REG_B_COLS: csr_prdata = DATA_W'(b_cols_ff);
         default:    csr_prdata = '0;
      endcase
   end

   assign dims.rows  = eff_dim(a_rows_ff);
   assign dims.inner = eff_dim(inner_ff);
   assign dims.cols  = eff_dim(b_cols_ff);

endmodule

// ----- design/zsmm_front.sv -----
// ----------------------------------------------------------------------------
// zsmm_front
// Request intake: decodes the action, drops requests with no effect and
// forwards loads and computes as jobs.
// ----------------------------------------------------------------------------
module zsmm_front
   import zsmm_pkg::*;
(
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic [3:0]         req_row_index,
   input  logic [3:0]         req_col_index,
   input  logic signed [31:0] req_elem_value,
   input  dims_type           dims,
   input  logic               queue_full,
   output logic               push,
   output job_type            push_job
);

   logic row_in_cap;
   logic col_in_cap;
   logic row_in_rows;
   logic keep;

   assign row_in_cap  = int'(req_row_index) < DIM_CAP;
   assign col_in_cap  = int'(req_col_index) < DIM_CAP;
   assign row_in_rows = int'(req_row_index) < int'(dims.rows);

   always_comb begin
      keep           = 1'b0;
      push_job.op    = OP_LOAD_A;
      push_job.row   = req_row_index[IDX_W-1:0];
      push_job.col   = req_col_index[IDX_W-1:0];
      push_job.value = req_elem_value;
      unique case (req_action)
         ACT_LOAD_A: begin
            keep        = row_in_cap && col_in_cap;
            push_job.op = OP_LOAD_A;
         end
         ACT_LOAD_B: begin
            keep        = row_in_cap && col_in_cap;
            push_job.op = OP_LOAD_B;
         end
         ACT_COMPUTE: begin
            keep        = row_in_rows;
            push_job.op = OP_COMPUTE;
         end
         default: keep = 1'b0;
      endcase
   end

   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready && keep;

endmodule

// ----- design/zsmm_queue.sv -----
// ----------------------------------------------------------------------------
// zsmm_queue
// Short job queue between intake and the compute engine.
// ----------------------------------------------------------------------------
module zsmm_queue
   import zsmm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type pop_job,
   output logic    empty
);

   job_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QPTR_W:0]    count_ff;

   assign full    = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_job = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + (QPTR_W+1)'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - (QPTR_W+1)'(1);
         end
      end
   end

endmodule

// ----- design/zsmm_engine.sv -----
// ----------------------------------------------------------------------------
// zsmm_engine
// Holds A and B, walks the inner dimension with one multiply lane per
// column, skips zero elements of A and streams the result row out.
// ----------------------------------------------------------------------------
module zsmm_engine
   import zsmm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  dims_type           dims,
   input  logic               job_valid,
   input  job_type            job,
   output logic               job_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [3:0]         rsp_out_row,
   output logic [3:0]         rsp_out_col,
   output logic signed [31:0] rsp_out_value,
   output logic               rsp_row_done
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   logic signed [31:0] a_mem [DIM_CAP][DIM_CAP];
   logic signed [31:0] b_mem [DIM_CAP][DIM_CAP];

   state_type          state_ff;
   logic [CNT_W-1:0]   k_ff;
   logic [CNT_W-1:0]   c_ff;
   logic [IDX_W-1:0]   row_ff;
   logic               rsp_valid_ff;
   logic [3:0]         out_row_ff;
   logic [3:0]         out_col_ff;
   logic signed [31:0] out_value_ff;
   logic               row_done_ff;

   logic               s1_v_ff;
   logic signed [31:0] a_rd_ff;
   logic signed [31:0] b_rd_ff [DIM_CAP];
   logic               s2_v_ff;
   logic               nz_ff;
   logic signed [63:0] prod_ff [DIM_CAP];
   logic signed [31:0] acc_ff  [DIM_CAP];
   logic signed [31:0] acc_in  [DIM_CAP];

   logic issue;
   logic start;
   logic k_last;
   logic c_last;
   logic load_out;

   assign job_pop  = (state_ff == ST_IDLE) && job_valid;
   assign start    = job_pop && (job.op == OP_COMPUTE);
   assign issue    = (state_ff == ST_WALK);
   assign k_last   = (k_ff == dims.inner - CNT_W'(1));
   assign c_last   = (c_ff == dims.cols - CNT_W'(1));
   assign load_out = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   // element stores
   always_ff @(posedge clock) begin
      if (job_pop && (job.op == OP_LOAD_A)) begin
         a_mem[job.row][job.col] <= job.value;
      end
      if (job_pop && (job.op == OP_LOAD_B)) begin
         b_mem[job.row][job.col] <= job.value;
      end
   end

   // stage 1: read A element and B row
   always_ff @(posedge clock) begin
      if (issue) begin
         a_rd_ff <= a_mem[row_ff][k_ff[IDX_W-1:0]];
         b_rd_ff <= b_mem[k_ff[IDX_W-1:0]];
      end
   end

   // stage 2: one product per column lane
   always_ff @(posedge clock) begin
      if (s1_v_ff) begin
         nz_ff <= (a_rd_ff != '0);
         for (int c = 0; c < DIM_CAP; c++) begin
            prod_ff[c] <= a_rd_ff * b_rd_ff[c];
         end
      end
   end

   // stage 3: floor shift, saturate, saturating accumulate
   always_comb begin
      for (int c = 0; c < DIM_CAP; c++) begin
         acc_in[c] = sat32(49'(acc_ff[c]) +
                           49'(sat32(49'($signed(prod_ff[c][63:16])))));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         for (int c = 0; c < DIM_CAP; c++) begin
            acc_ff[c] <= '0;
         end
      end else begin
         s1_v_ff <= issue;
         s2_v_ff <= s1_v_ff;
         if (start) begin
            for (int c = 0; c < DIM_CAP; c++) begin
               acc_ff[c] <= '0;
            end
         end else if (s2_v_ff && nz_ff) begin
            acc_ff <= acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         c_ff         <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         out_row_ff   <= '0;
         out_col_ff   <= '0;
         out_value_ff <= '0;
         row_done_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && !load_out) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  row_ff   <= job.row;
                  k_ff     <= '0;
                  state_ff <= ST_WALK;
               end
            end
            ST_WALK: begin
               k_ff <= k_ff + CNT_W'(1);
               if (k_last) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (!s1_v_ff && !s2_v_ff) begin
                  c_ff     <= '0;
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (load_out) begin
                  rsp_valid_ff <= 1'b1;
                  out_row_ff   <= 4'(row_ff);
                  out_col_ff   <= 4'(c_ff);
                  out_value_ff <= acc_ff[c_ff[IDX_W-1:0]];
                  row_done_ff  <= c_last;
                  c_ff         <= c_ff + CNT_W'(1);
                  if (c_last) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_row   = out_row_ff;
   assign rsp_out_col   = out_col_ff;
   assign rsp_out_value = out_value_ff;
   assign rsp_row_done  = row_done_ff;

endmodule

// ----- design/zero_skip_matrix_multiply_top.sv -----
// ----------------------------------------------------------------------------
// zero_skip_matrix_multiply_top
// Q16.16 matrix multiply, one result row per compute request, zero
// elements of A skip the matching row of B.
//
// Requests (req_*) load one element of A or B or ask for one result row.
// Loads are written into the A or B store and produce no result. A compute
// request walks the inner dimension at one element a cycle, all result
// columns in parallel, then streams b_col_count results (rsp_*), in column
// order, with rsp_row_done on the last. The read-multiply-accumulate pipe
// drains before the first result of a row goes out.
// A four-entry queue lets requests be taken while the engine is busy; the
// result register lets the engine move on while a result waits.
// Requests that name no valid element or row are taken and dropped.
// Reset (synchronous) empties the queue and pipe and sets all three
// dimension registers to 16; the A and B stores hold no reset value.
// A stalled receiver holds the engine in its output phase; requests keep
// being taken until the queue fills.
// ----------------------------------------------------------------------------
module zero_skip_matrix_multiply_top
   import zsmm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic [3:0]         req_row_index,
   input  logic [3:0]         req_col_index,
   input  logic signed [31:0] req_elem_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [3:0]         rsp_out_row,
   output logic [3:0]         rsp_out_col,
   output logic signed [31:0] rsp_out_value,
   output logic               rsp_row_done,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [PADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0]  csr_pwdata,
   output logic [DATA_W-1:0]  csr_prdata,
   output logic               csr_pready
);

   dims_type dims;
   logic     queue_full;
   logic     queue_empty;
   logic     push;
   logic     pop;
   job_type  push_job;
   job_type  pop_job;

   zsmm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .dims        (dims)
   );

   zsmm_front u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_row_index  (req_row_index),
      .req_col_index  (req_col_index),
      .req_elem_value (req_elem_value),
      .dims           (dims),
      .queue_full     (queue_full),
      .push           (push),
      .push_job       (push_job)
   );

   zsmm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .pop_job  (pop_job),
      .empty    (queue_empty)
   );

   zsmm_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .dims          (dims),
      .job_valid     (!queue_empty),
      .job           (pop_job),
      .job_pop       (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_out_value (rsp_out_value),
      .rsp_row_done  (rsp_row_done)
   );

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the zero-skip Q16.16 matrix multiply. Loads and
// compute requests go in over a valid/ready channel, dimensions are set
// over the APB port, and every result row is compared against a row
// predicted in the bench from its own copy of both matrices.
// ----------------------------------------------------------------------------
module tb;
   import zsmm_pkg::*;

   localparam logic [1:0] ACT_IGNORED = 2'd3;
   localparam int         DRAIN_CYCLES = 64;
   localparam logic signed [63:0] Q_MAX = 64'sd2147483647;
   localparam logic signed [63:0] Q_MIN = -64'sd2147483648;

   typedef struct packed {
      logic [3:0]         row;
      logic [3:0]         col;
      logic signed [31:0] value;
      logic               done;
   } product_entry_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_action = '0;
   logic [3:0]         req_row_index = '0;
   logic [3:0]         req_col_index = '0;
   logic signed [31:0] req_elem_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [3:0]         rsp_out_row;
   logic [3:0]         rsp_out_col;
   logic signed [31:0] rsp_out_value;
   logic               rsp_row_done;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [PADDR_W-1:0] csr_paddr = '0;
   logic [DATA_W-1:0]  csr_pwdata = '0;
   logic [DATA_W-1:0]  csr_prdata;
   logic               csr_pready;

   // bench copy of the block state
   logic signed [31:0] mat_a [16][16];
   logic signed [31:0] mat_b [16][16];
   bit                 mat_a_loaded [16][16];
   bit                 mat_b_loaded [16][16];
   logic [4:0]         dim_rows = 5'd16;
   logic [4:0]         dim_inner = 5'd16;
   logic [4:0]         dim_cols = 5'd16;

   product_entry_type awaited_products [$];

   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int stall_cycles = 0;
   int errors = 0;
   int requests_sent = 0;
   int loads_sent = 0;
   int computes_sent = 0;
   int ignored_sent = 0;
   int results_checked = 0;
   int settings_used = 0;

   zero_skip_matrix_multiply_top uut (.*);

   always #4 clock = ~clock;

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------
   function automatic int clamped_dim(input logic [4:0] r);
      if (r == 5'd0) return 1;
      if (int'(r) > DIM_CAP) return DIM_CAP;
      return int'(r);
   endfunction

   function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
      if (v > Q_MAX) return 32'sh7FFF_FFFF;
      if (v < Q_MIN) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // arithmetic shift floors, i.e. rounds toward minus infinity
   function automatic logic signed [31:0] q_product(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
      logic signed [63:0] wa;
      logic signed [63:0] wb;
      logic signed [63:0] p;
      wa = a;
      wb = b;
      p = wa * wb;
      return clip32(p >>> 16);
   endfunction

   function automatic void predict_row_products(input logic [3:0] row);
      int                 rows;
      int                 inner;
      int                 cols;
      logic signed [31:0] sums [16];
      logic signed [63:0] acc;
      logic signed [63:0] prod;
      product_entry_type  e;
      rows = clamped_dim(dim_rows);
      inner = clamped_dim(dim_inner);
      cols = clamped_dim(dim_cols);
      if (int'(row) >= rows) return;
      for (int c = 0; c < cols; c++) sums[c] = '0;
      for (int k = 0; k < inner; k++) begin
         if (mat_a[row][k] == 0) continue;
         for (int c = 0; c < cols; c++) begin
            acc = sums[c];
            prod = q_product(mat_a[row][k], mat_b[k][c]);
            sums[c] = clip32(acc + prod);
         end
      end
      for (int c = 0; c < cols; c++) begin
         e.row = row;
         e.col = 4'(c);
         e.value = sums[c];
         e.done = (c == cols - 1);
         awaited_products.push_back(e);
      end
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   function automatic logic [31:0] random_q();
      case ($urandom_range(9))
         0: return 32'h0000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         3, 4: return $urandom;
         default: return 32'($urandom_range(524287)) - 32'd262144;
      endcase
   endfunction

   // sparse A rows when the B rows behind them would be costly to fill
   function automatic logic [31:0] a_entry_value(input int work);
      if ($urandom_range(5) < ((work > 40) ? 1 : 4)) return random_q();
      return 32'h0000_0000;
   endfunction

   function automatic logic [4:0] random_dim();
      int pick;
      pick = $urandom_range(99);
      if (pick < 60) return 5'($urandom_range(1, 5));
      if (pick < 70) return 5'd0;
      if (pick < 85) return 5'($urandom_range(6, 16));
      return 5'($urandom_range(17, 31));
   endfunction

   task automatic report_mismatch(input string what);
      if (errors < 20) $display("%0t ns: mismatch: %s", $time, what);
      errors++;
   endtask

   task automatic send_request(input logic [1:0] act, input logic [3:0] row,
                               input logic [3:0] col, input logic [31:0] value);
      while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_row_index <= row;
      req_col_index <= col;
      req_elem_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      requests_sent++;
      case (act)
         ACT_LOAD_A: begin
            mat_a[row][col] = value;
            mat_a_loaded[row][col] = 1'b1;
            loads_sent++;
         end
         ACT_LOAD_B: begin
            mat_b[row][col] = value;
            mat_b_loaded[row][col] = 1'b1;
            loads_sent++;
         end
         ACT_COMPUTE: begin
            computes_sent++;
            predict_row_products(row);
         end
         default: ignored_sent++;
      endcase
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (awaited_products.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [4:0] dim);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= PADDR_W'({idx, 2'b00});
      csr_pwdata <= {27'($urandom), dim};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_A_ROWS: dim_rows = dim;
         REG_INNER:  dim_inner = dim;
         default:    dim_cols = dim;
      endcase
      @(posedge clock);
   endtask

   task automatic csr_check(input logic [1:0] idx, input logic [4:0] want);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= PADDR_W'({idx, 2'b00});
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      if (csr_prdata[CFG_W-1:0] !== want)
         report_mismatch($sformatf("register %0d reads %0d, want %0d",
                                   idx, csr_prdata[CFG_W-1:0], want));
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // every entry that a compute of this row will use gets written first
   task automatic prepare_row(input int row);
      int inner;
      int cols;
      inner = clamped_dim(dim_inner);
      cols = clamped_dim(dim_cols);
      for (int k = 0; k < inner; k++)
         if (!mat_a_loaded[row][k])
            send_request(ACT_LOAD_A, 4'(row), 4'(k), a_entry_value(inner * cols));
      for (int k = 0; k < inner; k++)
         if (mat_a[row][k] != 0)
            for (int c = 0; c < cols; c++)
               if (!mat_b_loaded[k][c])
                  send_request(ACT_LOAD_B, 4'(k), 4'(c), random_q());
   endtask

   task automatic random_request();
      int rows;
      int inner;
      int pick;
      int row;
      rows = clamped_dim(dim_rows);
      inner = clamped_dim(dim_inner);
      pick = $urandom_range(99);
      if (pick < 60) begin
         row = $urandom_range(rows - 1);
         prepare_row(row);
         send_request(ACT_COMPUTE, 4'(row), 4'($urandom), $urandom);
      end else if (pick < 68) begin
         row = $urandom_range(15);
         if (row < rows) prepare_row(row);
         send_request(ACT_COMPUTE, 4'(row), 4'($urandom), $urandom);
      end else if (pick < 85) begin
         send_request($urandom_range(1) ? ACT_LOAD_B : ACT_LOAD_A,
                      4'($urandom), 4'($urandom), random_q());
      end else if (pick < 95) begin
         send_request(ACT_LOAD_A, 4'($urandom_range(rows - 1)),
                      4'($urandom_range(inner - 1)), random_q());
      end else begin
         send_request(ACT_IGNORED, 4'($urandom), 4'($urandom), $urandom);
      end
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   task automatic test_registers();
      csr_check(REG_A_ROWS, 5'(RESET_DIM));
      csr_check(REG_INNER, 5'(RESET_DIM));
      csr_check(REG_B_COLS, 5'(RESET_DIM));
      csr_write(REG_A_ROWS, 5'd31);
      csr_write(REG_INNER, 5'd0);
      csr_write(REG_B_COLS, 5'd7);
      csr_check(REG_A_ROWS, 5'd31);
      csr_check(REG_INNER, 5'd0);
      csr_check(REG_B_COLS, 5'd7);
   endtask

   task automatic test_directed();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      settle();
      csr_write(REG_A_ROWS, 5'd2);
      csr_write(REG_INNER, 5'd2);
      csr_write(REG_B_COLS, 5'd2);
      settings_used++;
      send_request(ACT_LOAD_A, 4'd0, 4'd0, 32'h7FFF_FFFF);
      send_request(ACT_LOAD_A, 4'd0, 4'd1, 32'h7FFF_FFFF);
      send_request(ACT_LOAD_A, 4'd1, 4'd0, 32'hFFFF_FFFF);
      send_request(ACT_LOAD_A, 4'd1, 4'd1, 32'h0000_0000);
      send_request(ACT_LOAD_B, 4'd0, 4'd0, 32'h7FFF_FFFF);
      send_request(ACT_LOAD_B, 4'd0, 4'd1, 32'h0000_0001);
      send_request(ACT_LOAD_B, 4'd1, 4'd0, 32'h7FFF_FFFF);
      send_request(ACT_LOAD_B, 4'd1, 4'd1, 32'h8000_0000);
      // saturating sums, then floor rounding with a zero that skips B row 1
      send_request(ACT_COMPUTE, 4'd0, 4'd15, 32'hFFFF_FFFF);
      send_request(ACT_COMPUTE, 4'd1, 4'd0, 32'h0000_0000);
      // rows past the configured count give nothing
      send_request(ACT_COMPUTE, 4'd2, 4'd0, 32'h0000_0000);
      send_request(ACT_COMPUTE, 4'd15, 4'd15, 32'hFFFF_FFFF);
      send_request(ACT_IGNORED, 4'd15, 4'd15, 32'hFFFF_FFFF);
      // outside the configured size but inside the store
      send_request(ACT_LOAD_A, 4'd15, 4'd15, 32'h5555_AAAA);
      send_request(ACT_LOAD_B, 4'd15, 4'd15, 32'hAAAA_5555);
      send_request(ACT_LOAD_A, 4'd15, 4'd0, 32'hFFFF_0000);
      settle();
      // zero acts as one, above the capacity acts as the capacity
      csr_write(REG_A_ROWS, 5'd31);
      csr_write(REG_INNER, 5'd0);
      csr_write(REG_B_COLS, 5'd0);
      settings_used++;
      send_request(ACT_COMPUTE, 4'd15, 4'd3, 32'h1234_5678);
      send_request(ACT_COMPUTE, 4'd0, 4'd0, 32'h0000_0000);
   endtask

   task automatic test_random_traffic(input int tx_pct, input int rx_pct,
                                      input int target);
      int start;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      start = requests_sent;
      while (requests_sent - start < target) begin
         settle();
         csr_write(REG_A_ROWS, random_dim());
         csr_write(REG_INNER, random_dim());
         csr_write(REG_B_COLS, random_dim());
         settings_used++;
         repeat ($urandom_range(15, 30)) random_request();
      end
   endtask

   task automatic test_receiver_stall();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      settle();
      csr_write(REG_A_ROWS, 5'd3);
      csr_write(REG_INNER, 5'd1);
      csr_write(REG_B_COLS, 5'd31);
      settings_used++;
      for (int r = 0; r < 3; r++) prepare_row(r);
      stall_cycles = 400;
      repeat (10) send_request(ACT_COMPUTE, 4'($urandom_range(2)), 4'($urandom), $urandom);
   endtask

   // ------------------------------------------------------------------
   // receiver and result check
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (stall_cycles > 0) begin
         stall_cycles--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin : check_products
      product_entry_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (awaited_products.size() == 0) begin
            report_mismatch($sformatf("unexpected result row %0d col %0d value %h",
                                      rsp_out_row, rsp_out_col, rsp_out_value));
         end else begin
            want = awaited_products.pop_front();
            results_checked++;
            if (rsp_out_row !== want.row || rsp_out_col !== want.col ||
                rsp_out_value !== want.value || rsp_row_done !== want.done)
               report_mismatch($sformatf(
                  "got row %0d col %0d value %h done %b, want %0d %0d %h %b",
                  rsp_out_row, rsp_out_col, rsp_out_value, rsp_row_done,
                  want.row, want.col, want.value, want.done));
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_registers();
      test_directed();
      test_random_traffic(33, 67, 85);
      test_random_traffic(67, 33, 85);
      test_random_traffic(0, 0, 85);
      test_receiver_stall();
      settle();
      $display("%0d requests: %0d loads, %0d row computes, %0d ignored",
               requests_sent, loads_sent, computes_sent, ignored_sent);
      $display("%0d results checked over %0d dimension settings, one long receiver stall",
               results_checked, settings_used);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
